### src/tone_step_sequencer_core_macros.svh
// ----------------------------------------------------------------------------
// tone step sequencer assertion macros
// clocked property wrappers used by the sequencer core
// ----------------------------------------------------------------------------
`ifndef TONE_STEP_SEQUENCER_CORE_MACROS_SVH
`define TONE_STEP_SEQUENCER_CORE_MACROS_SVH

// same-cycle implication
`define TSS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/tss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_pkg
// shared widths, codes, types and helpers of the tone step sequencer
// ----------------------------------------------------------------------------
package tss_pkg;

    localparam int STEP_DEPTH_DEF  = 1024;
    localparam int CHANNELS_DEF    = 3;
    localparam int PITCH_SHIFT_DEF = 14;

    localparam int OPCODE_W    = 2;
    localparam int CH_FIELD_W  = 2;
    localparam int ADDR_IN_W   = 10;
    localparam int ADDR_IN_MAX = 1023;
    localparam int DUR_W       = 8;
    localparam int PITCH_W     = 16;
    localparam int VOL_W       = 4;
    localparam int SCALE_W     = 10;
    localparam int AMP_W       = VOL_W + SCALE_W;
    localparam int REG_IDX_W   = 3;
    localparam int REG_VAL_W   = 30;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 32;
    localparam int CFG_IDX_W   = 1;

    localparam logic [SCALE_W-1:0] MUSIC_SCALE_RST  = 10'd400;
    localparam logic [SCALE_W-1:0] EFFECT_SCALE_RST = 10'd700;

    localparam logic [CFG_IDX_W-1:0] CFG_MUSIC_SCALE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EFFECT_SCALE = 1'b1;

    localparam logic [OPCODE_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_START = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_LOAD  = 2'd2;

    localparam logic [REG_IDX_W-1:0] REG_NOISE = 3'd6;
    localparam int EFFECT_CH = 2;

    typedef struct packed {
        logic               noise;
        logic [VOL_W-1:0]   volume;
        logic [PITCH_W-1:0] pitch;
        logic [DUR_W-1:0]   duration;
    } t_step;

    typedef struct packed {
        logic                 emit;
        logic                 done;
        logic [REG_IDX_W-1:0] idx;
        logic [REG_VAL_W-1:0] value;
    } t_wr_req;

    // address field reduced into the step memory range (for a depth of at least 8) by compare and subtract
    function automatic int unsigned mod_depth(input int unsigned value,
                                              input int unsigned depth);
        int unsigned rem;
        rem = value;
        for (int k = 6; k >= 0; k--) begin
            if (((depth << k) <= ADDR_IN_MAX) && (rem >= (depth << k))) begin
                rem = rem - (depth << k);
            end
        end
        return rem;
    endfunction

endpackage

### src/tone_step_sequencer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tone_step_sequencer_core
// three-channel note sequencer producing tone and noise synthesizer writes
// ----------------------------------------------------------------------------
// Items are taken one at a time. A load, or a start that sets a sequence
// present, is finished when it is accepted. A stop (a start without a
// sequence) issues its one write. A frame tick is accepted and then checks
// each channel in turn. A channel whose counter runs out reads the step
// memory (and reads it again when a loop jumps back), then issues its
// register writes one at a time. The step memory read is synchronous, and
// a single write is issued per cycle while the output stage has room; a full
// output stage holds the write cycles until i_m_axis_tready frees it. The output
// register lets the next item enter while the last write of the previous one
// still waits on i_m_axis_tready. The channel state resets to idle at once;
// the step memory has no reset and must be loaded before a channel plays it.
module tone_step_sequencer_core #(
    parameter int STEP_DEPTH  = tss_pkg::STEP_DEPTH_DEF,
    parameter int CHANNELS    = tss_pkg::CHANNELS_DEF,
    parameter int PITCH_SHIFT = tss_pkg::PITCH_SHIFT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // channel [1:0], seq_start [11:2], seq_present [12], loop_enable [13],
    // step_addr [23:14], step_duration [31:24], step_pitch [47:32],
    // step_volume [51:48], step_noise [52]
    input  logic [tss_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,
    // opcode [1:0]
    input  logic [tss_pkg::OPCODE_W-1:0]        i_s_axis_tuser,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // reg_value [29:0]
    output logic [tss_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata,
    // reg_index [2:0]
    output logic [tss_pkg::REG_IDX_W-1:0]       o_m_axis_tuser,
    output logic                                o_m_axis_tlast,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    input  logic                                i_cfg_we,
    input  logic [tss_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [tss_pkg::SCALE_W-1:0]         i_cfg_data
);

    `include "tone_step_sequencer_core_macros.svh"

    localparam int AW      = $clog2(STEP_DEPTH);
    localparam int CH_W    = $clog2(CHANNELS);
    localparam int OUT_PAD = tss_pkg::OUT_TDATA_W - tss_pkg::REG_VAL_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_STEP,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        KIND_STOP,
        KIND_NOISE,
        KIND_TONE
    } t_kind;

    // input fields
    logic [tss_pkg::CH_FIELD_W-1:0] in_channel;
    logic [tss_pkg::ADDR_IN_W-1:0]  in_seq_start;
    logic                           in_seq_present;
    logic                           in_loop_enable;
    logic [tss_pkg::ADDR_IN_W-1:0]  in_step_addr;
    tss_pkg::t_step                 in_step;
    logic [AW-1:0]                  start_addr;
    logic [AW-1:0]                  load_addr;
    logic                           accept;

    assign in_channel     = i_s_axis_tdata[1:0];
    assign in_seq_start   = i_s_axis_tdata[11:2];
    assign in_seq_present = i_s_axis_tdata[12];
    assign in_loop_enable = i_s_axis_tdata[13];
    assign in_step_addr   = i_s_axis_tdata[23:14];
    assign in_step.duration = i_s_axis_tdata[31:24];
    assign in_step.pitch    = i_s_axis_tdata[47:32];
    assign in_step.volume   = i_s_axis_tdata[51:48];
    assign in_step.noise    = i_s_axis_tdata[52];

    assign start_addr = AW'(tss_pkg::mod_depth(32'(in_seq_start), STEP_DEPTH));
    assign load_addr  = AW'(tss_pkg::mod_depth(32'(in_step_addr), STEP_DEPTH));

    // state
    t_state                        r_state, n_state;
    logic [CH_W-1:0]               r_ch, n_ch;
    logic                          r_tick, n_tick;
    logic                          r_jumped, n_jumped;
    t_kind                         r_kind, n_kind;
    logic [tss_pkg::PITCH_W-1:0]   r_pitch, n_pitch;
    logic [tss_pkg::VOL_W-1:0]     r_vol, n_vol;
    logic [1:0]                    r_pos, n_pos;
    logic [AW-1:0]                 r_ptr [CHANNELS];
    logic [AW-1:0]                 n_ptr [CHANNELS];
    logic [AW-1:0]                 r_origin [CHANNELS];
    logic [AW-1:0]                 n_origin [CHANNELS];
    logic [tss_pkg::DUR_W-1:0]     r_cnt [CHANNELS];
    logic [tss_pkg::DUR_W-1:0]     n_cnt [CHANNELS];
    logic [CHANNELS-1:0]           r_active, n_active;
    logic [CHANNELS-1:0]           r_loops, n_loops;
    logic [tss_pkg::SCALE_W-1:0]   r_music_scale;
    logic [tss_pkg::SCALE_W-1:0]   r_effect_scale;

    // datapath
    tss_pkg::t_wr_req              w_wr;
    logic                          w_can_emit;
    logic                          rd_en;
    logic [AW-1:0]                 rd_addr;
    tss_pkg::t_step                rd_data;
    logic                          mem_we;
    logic                          last_ch;
    logic                          effect_ch;
    logic [tss_pkg::DUR_W-1:0]     cnt_dec;
    logic [AW:0]                   ptr_sum;
    logic [AW-1:0]                 ptr_inc;
    logic [tss_pkg::SCALE_W-1:0]   ch_scale;
    logic [tss_pkg::AMP_W-1:0]     ch_amp;
    logic [tss_pkg::AMP_W-1:0]     noise_amp;
    logic [tss_pkg::REG_IDX_W-1:0] amp_idx;
    logic [tss_pkg::REG_IDX_W-1:0] pitch_idx;
    logic [tss_pkg::REG_VAL_W-1:0] pitch_val;
    logic [1:0]                    emit_cnt;
    logic [tss_pkg::REG_IDX_W-1:0] e_idx;
    logic [tss_pkg::REG_VAL_W-1:0] e_val;

    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);

    assign last_ch   = (r_ch == CH_W'(CHANNELS - 1));
    assign effect_ch = (r_ch == CH_W'(tss_pkg::EFFECT_CH));
    assign cnt_dec   = r_cnt[r_ch] - tss_pkg::DUR_W'(1);
    assign ptr_sum   = {1'b0, r_ptr[r_ch]} + (AW + 1)'(1);
    assign ptr_inc   = (ptr_sum == (AW + 1)'(STEP_DEPTH)) ? '0 : ptr_sum[AW-1:0];

    assign ch_scale  = effect_ch ? r_effect_scale : r_music_scale;
    assign ch_amp    = r_vol * ch_scale;
    assign noise_amp = r_vol * r_effect_scale;
    assign amp_idx   = tss_pkg::REG_IDX_W'(CHANNELS) + tss_pkg::REG_IDX_W'(r_ch);
    assign pitch_idx = tss_pkg::REG_IDX_W'(r_ch);
    assign pitch_val = tss_pkg::REG_VAL_W'(r_pitch) << PITCH_SHIFT;

    // write list of the current channel
    always_comb begin
        e_idx = amp_idx;
        e_val = '0;
        unique case (r_kind)
            KIND_STOP: begin
                emit_cnt = (r_tick && effect_ch) ? 2'd2 : 2'd1;
                if (r_pos != 2'd0) begin
                    e_idx = tss_pkg::REG_NOISE;
                end
            end
            KIND_NOISE: begin
                emit_cnt = 2'd2;
                if (r_pos == 2'd0) begin
                    e_idx = tss_pkg::REG_NOISE;
                    e_val = tss_pkg::REG_VAL_W'(noise_amp);
                end
            end
            KIND_TONE: begin
                emit_cnt = effect_ch ? 2'd3 : 2'd2;
                unique case (r_pos)
                    2'd0: begin
                        e_idx = pitch_idx;
                        e_val = pitch_val;
                    end
                    2'd1: e_val = tss_pkg::REG_VAL_W'(ch_amp);
                    default: e_idx = tss_pkg::REG_NOISE;
                endcase
            end
            default: emit_cnt = 2'd1;
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_ch     = r_ch;
        n_tick   = r_tick;
        n_jumped = r_jumped;
        n_kind   = r_kind;
        n_pitch  = r_pitch;
        n_vol    = r_vol;
        n_pos    = r_pos;
        n_ptr    = r_ptr;
        n_origin = r_origin;
        n_cnt    = r_cnt;
        n_active = r_active;
        n_loops  = r_loops;
        w_wr     = '0;
        rd_en    = 1'b0;
        rd_addr  = r_ptr[r_ch];
        mem_we   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    priority if (i_s_axis_tuser == tss_pkg::OP_TICK) begin
                        n_ch    = '0;
                        n_tick  = 1'b1;
                        n_state = S_CHECK;
                    end else if ((i_s_axis_tuser == tss_pkg::OP_START)
                                 && (in_channel < tss_pkg::CH_FIELD_W'(CHANNELS))) begin
                        n_ptr[in_channel[CH_W-1:0]]    = start_addr;
                        n_origin[in_channel[CH_W-1:0]] = start_addr;
                        n_cnt[in_channel[CH_W-1:0]]    = tss_pkg::DUR_W'(1);
                        n_loops[in_channel[CH_W-1:0]]  = in_loop_enable;
                        n_active[in_channel[CH_W-1:0]] = in_seq_present;
                        if (in_seq_present) begin
                            w_wr.done = 1'b1;
                        end else begin
                            n_ch    = in_channel[CH_W-1:0];
                            n_tick  = 1'b0;
                            n_kind  = KIND_STOP;
                            n_pos   = 2'd0;
                            n_state = S_EMIT;
                        end
                    end else if (i_s_axis_tuser == tss_pkg::OP_LOAD) begin
                        mem_we    = 1'b1;
                        w_wr.done = 1'b1;
                    end else begin
                        w_wr.done = 1'b1;
                    end
                end
            end
            S_CHECK: begin
                if (r_active[r_ch]) begin
                    n_cnt[r_ch] = cnt_dec;
                end
                if (r_active[r_ch] && (cnt_dec == '0)) begin
                    rd_en    = 1'b1;
                    n_jumped = 1'b0;
                    n_state  = S_STEP;
                end else if (last_ch) begin
                    w_wr.done = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    n_ch = r_ch + CH_W'(1);
                end
            end
            S_STEP: begin
                if (rd_data.duration == '0) begin
                    if (r_loops[r_ch] && !r_jumped) begin
                        n_ptr[r_ch] = r_origin[r_ch];
                        n_jumped    = 1'b1;
                        rd_en       = 1'b1;
                        rd_addr     = r_origin[r_ch];
                    end else begin
                        n_active[r_ch] = 1'b0;
                        n_kind         = KIND_STOP;
                        n_pos          = 2'd0;
                        n_state        = S_EMIT;
                    end
                end else begin
                    n_cnt[r_ch] = rd_data.duration;
                    n_ptr[r_ch] = ptr_inc;
                    n_kind      = rd_data.noise ? KIND_NOISE : KIND_TONE;
                    n_pitch     = rd_data.pitch;
                    n_vol       = rd_data.volume;
                    n_pos       = 2'd0;
                    n_state     = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_can_emit) begin
                    w_wr.emit  = 1'b1;
                    w_wr.idx   = e_idx;
                    w_wr.value = e_val;
                    if (r_pos == emit_cnt - 2'd1) begin
                        if (r_tick && !last_ch) begin
                            n_ch    = r_ch + CH_W'(1);
                            n_state = S_CHECK;
                        end else begin
                            w_wr.done = 1'b1;
                            n_state   = S_IDLE;
                        end
                    end else begin
                        n_pos = r_pos + 2'd1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ch     <= '0;
            r_tick   <= 1'b0;
            r_jumped <= 1'b0;
            r_kind   <= KIND_STOP;
            r_pos    <= 2'd0;
            r_active <= '0;
            r_loops  <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_ptr[c]    <= '0;
                r_origin[c] <= '0;
                r_cnt[c]    <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_ch     <= n_ch;
            r_tick   <= n_tick;
            r_jumped <= n_jumped;
            r_kind   <= n_kind;
            r_pos    <= n_pos;
            r_active <= n_active;
            r_loops  <= n_loops;
            r_ptr    <= n_ptr;
            r_origin <= n_origin;
            r_cnt    <= n_cnt;
        end
        r_pitch <= n_pitch;
        r_vol   <= n_vol;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_music_scale  <= tss_pkg::MUSIC_SCALE_RST;
            r_effect_scale <= tss_pkg::EFFECT_SCALE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tss_pkg::CFG_MUSIC_SCALE:  r_music_scale  <= i_cfg_data;
                tss_pkg::CFG_EFFECT_SCALE: r_effect_scale <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tss_step_mem #(
        .DEPTH (STEP_DEPTH)
    ) u_step_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (load_addr),
        .i_wdata (in_step),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    logic [tss_pkg::REG_VAL_W-1:0] out_value;

    tss_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (w_wr),
        .o_can_emit (w_can_emit),
        .i_m_tready (i_m_axis_tready),
        .o_m_tvalid (o_m_axis_tvalid),
        .o_m_idx    (o_m_axis_tuser),
        .o_m_value  (out_value),
        .o_m_last   (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {{OUT_PAD{1'b0}}, out_value};

    `TSS_ASSERT_NOW(a_emit_has_room, w_wr.emit, w_can_emit, "write with output stage full")
    `TSS_ASSERT_NOW(a_step_on_active, r_state == S_STEP, r_active[r_ch], "fetch on idle channel")
    `TSS_ASSERT_NOW(a_emit_pos, r_state == S_EMIT, r_pos < emit_cnt, "write list overrun")
    `TSS_ASSERT_NEXT(a_read_lands, (r_state == S_CHECK) && rd_en, r_state == S_STEP, "read lost")

endmodule

### src/tss_step_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_step_mem
// step memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module tss_step_mem #(
    parameter int DEPTH = tss_pkg::STEP_DEPTH_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  tss_pkg::t_step  i_wdata,
    input  logic            i_re,
    input  logic [AW-1:0]   i_raddr,
    output tss_pkg::t_step  o_rdata
);

    tss_pkg::t_step r_mem [DEPTH];
    tss_pkg::t_step r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/tss_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_out_stage
// holds one register write until its last flag is known, then an output register
// ----------------------------------------------------------------------------
module tss_out_stage (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  tss_pkg::t_wr_req                   i_wr,
    output logic                               o_can_emit,
    input  logic                               i_m_tready,
    output logic                               o_m_tvalid,
    output logic [tss_pkg::REG_IDX_W-1:0]      o_m_idx,
    output logic [tss_pkg::REG_VAL_W-1:0]      o_m_value,
    output logic                               o_m_last
);

    logic                            r_pend_valid;
    logic                            r_pend_final;
    logic [tss_pkg::REG_IDX_W-1:0]   r_pend_idx;
    logic [tss_pkg::REG_VAL_W-1:0]   r_pend_value;
    logic                            r_out_valid;
    logic [tss_pkg::REG_IDX_W-1:0]   r_out_idx;
    logic [tss_pkg::REG_VAL_W-1:0]   r_out_value;
    logic                            r_out_last;

    logic out_free;
    logic pend_last;
    logic pend_move;

    assign out_free   = !r_out_valid || i_m_tready;
    assign o_can_emit = !r_pend_valid || out_free;
    assign pend_last  = r_pend_final || (i_wr.done && !i_wr.emit);
    assign pend_move  = r_pend_valid && out_free && (i_wr.emit || pend_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_pend_final <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_wr.emit) begin
                r_pend_valid <= 1'b1;
                r_pend_final <= i_wr.done;
            end else if (pend_move) begin
                r_pend_valid <= 1'b0;
            end else if (i_wr.done && r_pend_valid) begin
                r_pend_final <= 1'b1;
            end
            if (pend_move) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.emit) begin
            r_pend_idx   <= i_wr.idx;
            r_pend_value <= i_wr.value;
        end
        if (pend_move) begin
            r_out_idx   <= r_pend_idx;
            r_out_value <= r_pend_value;
            r_out_last  <= pend_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_idx    = r_out_idx;
    assign o_m_value  = r_out_value;
    assign o_m_last   = r_out_last;

endmodule

### sim/tb_tone_step_sequencer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tone_step_sequencer_core
// self-checking bench for the three-channel tone step sequencer
// ----------------------------------------------------------------------------
// Loads step sequences and starts, stops and ticks the channels through the
// input stream. A scoreboard class keeps its own copy of the step memory and
// channel state, predicts the synthesizer register writes of every accepted
// transaction and compares each output transaction in order. Step loads keep
// every non-end step followed by a loaded entry, so no channel ever reads an
// unloaded step. Three random phases change both scale registers and the
// idle mix on each side; one phase holds the output off long enough to stall
// the input, another drains everything in the middle.
// ----------------------------------------------------------------------------
module tb_tone_step_sequencer_core;

    localparam int NUM_CH      = tss_pkg::CHANNELS_DEF;
    localparam int MEM_DEPTH   = tss_pkg::STEP_DEPTH_DEF;
    localparam int SHIFT       = tss_pkg::PITCH_SHIFT_DEF;
    localparam int DRAIN_WAIT  = 40;
    localparam int HOLD_CYCLES = 150;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [tss_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [2:0]                  pad;
        logic                        step_noise;
        logic [tss_pkg::VOL_W-1:0]   step_volume;
        logic [tss_pkg::PITCH_W-1:0] step_pitch;
        logic [tss_pkg::DUR_W-1:0]   step_duration;
        logic [9:0]                  step_addr;
        logic                        loop_enable;
        logic                        seq_present;
        logic [9:0]                  seq_start;
        logic [1:0]                  channel;
    } t_seq_item;

    typedef struct {
        logic [tss_pkg::REG_IDX_W-1:0] idx;
        logic [tss_pkg::REG_VAL_W-1:0] value;
        logic                          last;
    } t_synth_write;

    class t_synth_scoreboard;
        tss_pkg::t_step              steps[MEM_DEPTH];
        logic [9:0]                  step_ptr[NUM_CH];
        logic [9:0]                  origin[NUM_CH];
        logic [tss_pkg::DUR_W-1:0]   frames[NUM_CH];
        bit                          active[NUM_CH];
        bit                          looping[NUM_CH];
        logic [tss_pkg::SCALE_W-1:0] music_scale;
        logic [tss_pkg::SCALE_W-1:0] effect_scale;
        t_synth_write                expected_q[$];
        t_synth_write                burst[$];

        function new();
            foreach (steps[i]) steps[i] = '0;
            for (int c = 0; c < NUM_CH; c++) begin
                step_ptr[c] = '0;
                origin[c]   = '0;
                frames[c]   = '0;
                active[c]   = 1'b0;
                looping[c]  = 1'b0;
            end
            music_scale  = tss_pkg::MUSIC_SCALE_RST;
            effect_scale = tss_pkg::EFFECT_SCALE_RST;
        endfunction

        function void set_scale(logic [tss_pkg::CFG_IDX_W-1:0] idx,
                                logic [tss_pkg::SCALE_W-1:0] value);
            if (idx == tss_pkg::CFG_MUSIC_SCALE) music_scale = value;
            else effect_scale = value;
        endfunction

        function void push_write(int idx, logic [tss_pkg::REG_VAL_W-1:0] value);
            t_synth_write w;
            w.idx   = tss_pkg::REG_IDX_W'(idx);
            w.value = value;
            w.last  = 1'b0;
            burst.push_back(w);
        endfunction

        function logic [tss_pkg::REG_VAL_W-1:0] amplitude(int ch,
                                                          logic [tss_pkg::VOL_W-1:0] vol);
            logic [tss_pkg::SCALE_W-1:0] scale;
            scale = (ch == tss_pkg::EFFECT_CH) ? effect_scale : music_scale;
            return tss_pkg::REG_VAL_W'(vol) * tss_pkg::REG_VAL_W'(scale);
        endfunction

        function void play_channel(int ch);
            tss_pkg::t_step st;
            bit             jumped;
            jumped = 1'b0;
            if (!active[ch]) return;
            frames[ch] = frames[ch] - 1'b1;
            if (frames[ch] != 0) return;
            forever begin
                st = steps[step_ptr[ch]];
                if (st.duration != 0) break;
                if (looping[ch] && !jumped) begin
                    step_ptr[ch] = origin[ch];
                    jumped = 1'b1;
                end else begin
                    active[ch] = 1'b0;
                    push_write(NUM_CH + ch, '0);
                    if (ch == tss_pkg::EFFECT_CH) push_write(tss_pkg::REG_NOISE, '0);
                    return;
                end
            end
            frames[ch] = st.duration;
            if (st.noise) begin
                push_write(tss_pkg::REG_NOISE, amplitude(tss_pkg::EFFECT_CH, st.volume));
                push_write(NUM_CH + ch, '0);
            end else begin
                push_write(ch, tss_pkg::REG_VAL_W'(st.pitch) << SHIFT);
                push_write(NUM_CH + ch, amplitude(ch, st.volume));
                if (ch == tss_pkg::EFFECT_CH) push_write(tss_pkg::REG_NOISE, '0);
            end
            step_ptr[ch] = step_ptr[ch] + 10'd1;
        endfunction

        function void note_item(logic [tss_pkg::OPCODE_W-1:0] op, t_seq_item it);
            int ch;
            burst.delete();
            ch = int'(it.channel);
            if (op == tss_pkg::OP_TICK) begin
                for (int c = 0; c < NUM_CH; c++) play_channel(c);
            end else if (op == tss_pkg::OP_START) begin
                if (ch < NUM_CH) begin
                    step_ptr[ch] = it.seq_start;
                    origin[ch]   = it.seq_start;
                    frames[ch]   = 8'd1;
                    looping[ch]  = it.loop_enable;
                    active[ch]   = it.seq_present;
                    if (!it.seq_present) push_write(NUM_CH + ch, '0);
                end
            end else if (op == tss_pkg::OP_LOAD) begin
                steps[it.step_addr] = {it.step_noise, it.step_volume, it.step_pitch,
                                       it.step_duration};
            end
            if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
            foreach (burst[i]) expected_q.push_back(burst[i]);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function bit check_write(logic [tss_pkg::REG_IDX_W-1:0] idx,
                                 logic [tss_pkg::OUT_TDATA_W-1:0] data,
                                 logic last, output string why);
            t_synth_write w;
            why = "";
            if (expected_q.size() == 0) begin
                $sformat(why, "unexpected write idx %0d value 0x%08h last %0b",
                         idx, data, last);
                return 1'b0;
            end
            w = expected_q.pop_front();
            if (idx !== w.idx || data !== tss_pkg::OUT_TDATA_W'(w.value)
                || last !== w.last) begin
                $sformat(why, "write got idx %0d value 0x%08h last %0b, exp %0d 0x%08h %0b",
                         idx, data, last, w.idx, tss_pkg::OUT_TDATA_W'(w.value), w.last);
                return 1'b0;
            end
            return 1'b1;
        endfunction
    endclass

    logic                              i_clk;
    logic                              i_rst_n;
    logic [tss_pkg::IN_TDATA_W-1:0]    s_tdata;
    logic [tss_pkg::OPCODE_W-1:0]      s_tuser;
    logic                              s_tvalid;
    logic                              s_tready;
    logic [tss_pkg::OUT_TDATA_W-1:0]   m_tdata;
    logic [tss_pkg::REG_IDX_W-1:0]     m_tuser;
    logic                              m_tlast;
    logic                              m_tvalid;
    logic                              m_tready;
    logic                              cfg_we;
    logic [tss_pkg::CFG_IDX_W-1:0]     cfg_idx;
    logic [tss_pkg::SCALE_W-1:0]       cfg_data;

    t_synth_scoreboard sb;
    int    error_count;
    int    cycle_count;
    int    sent_count;
    int    send_idle_pct;
    int    recv_idle_pct;
    int    hold_left;
    bit    hold_req;
    bit    step_written[MEM_DEPTH];
    int    seq_heads[$];
    string check_note;

    tone_step_sequencer_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    // output side: random stalls plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            if (!sb.check_write(m_tuser, m_tdata, m_tlast, check_note))
                report_mismatch(check_note);
        end
    end

    function automatic t_seq_item random_fields();
        logic [63:0] r;
        t_seq_item   it;
        r = {$urandom(), $urandom()};
        it = t_seq_item'(r[tss_pkg::IN_TDATA_W-1:0]);
        it.pad = '0;
        return it;
    endfunction

    task automatic send_item(input logic [tss_pkg::OPCODE_W-1:0] op, input t_seq_item it);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tdata  <= it;
        s_tuser  <= op;
        s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_tready);
        sb.note_item(op, it);
        if (!(op == OP_UNUSED || (op == tss_pkg::OP_START && int'(it.channel) >= NUM_CH)))
            sent_count++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_scales(input logic [tss_pkg::SCALE_W-1:0] music,
                                input logic [tss_pkg::SCALE_W-1:0] effect);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= tss_pkg::CFG_MUSIC_SCALE;
        cfg_data <= music;
        @(negedge i_clk);
        cfg_idx  <= tss_pkg::CFG_EFFECT_SCALE;
        cfg_data <= effect;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        sb.set_scale(tss_pkg::CFG_MUSIC_SCALE, music);
        sb.set_scale(tss_pkg::CFG_EFFECT_SCALE, effect);
    endtask

    task automatic do_tick();
        send_item(tss_pkg::OP_TICK, random_fields());
    endtask

    task automatic load_step(input logic [9:0] addr, input logic [tss_pkg::DUR_W-1:0] dur,
                             input logic [tss_pkg::PITCH_W-1:0] pitch,
                             input logic [tss_pkg::VOL_W-1:0] vol,
                             input logic noise);
        t_seq_item it;
        it = random_fields();
        it.step_addr     = addr;
        it.step_duration = dur;
        it.step_pitch    = pitch;
        it.step_volume   = vol;
        it.step_noise    = noise;
        step_written[addr] = 1'b1;
        send_item(tss_pkg::OP_LOAD, it);
    endtask

    task automatic start_channel(input logic [1:0] ch, input logic [9:0] start,
                                 input logic present, input logic loop_en);
        t_seq_item it;
        it = random_fields();
        it.channel     = ch;
        it.seq_start   = start;
        it.seq_present = present;
        it.loop_enable = loop_en;
        send_item(tss_pkg::OP_START, it);
    endtask

    // end step first, then the notes backwards so each note has a loaded successor
    task automatic load_sequence(input logic [9:0] base, input int n);
        logic [tss_pkg::DUR_W-1:0] dur;
        load_step(base + 10'(n), '0, 16'($urandom()), 4'($urandom()), 1'($urandom()));
        for (int k = n - 1; k >= 0; k--) begin
            dur = ($urandom_range(0, 19) == 0) ? tss_pkg::DUR_W'($urandom_range(4, 255))
                                               : tss_pkg::DUR_W'($urandom_range(1, 3));
            load_step(base + 10'(k), dur, 16'($urandom()), 4'($urandom()),
                      ($urandom_range(0, 3) == 0));
        end
        seq_heads.push_back(int'(base));
    endtask

    task automatic random_load();
        logic [9:0] addr;
        addr = 10'($urandom());
        load_step(addr, step_written[addr + 10'd1] ? tss_pkg::DUR_W'($urandom()) : '0,
                  16'($urandom()), 4'($urandom()), 1'($urandom()));
    endtask

    task automatic random_start();
        logic [1:0] ch;
        logic       present;
        logic [9:0] start;
        ch      = 2'($urandom_range(0, 3));
        present = ($urandom_range(0, 9) < 8);
        start   = present ? 10'(seq_heads[$urandom_range(0, seq_heads.size() - 1)])
                          : 10'($urandom());
        start_channel(ch, start, present, 1'($urandom()));
    endtask

    task automatic run_random(input int n_items, input bit do_hold, input bit do_pause);
        int target;
        int pick;
        bit mid_done;
        target   = sent_count + n_items;
        mid_done = 1'b0;
        while (sent_count < target) begin
            if (!mid_done && sent_count >= target - n_items / 2) begin
                mid_done = 1'b1;
                if (do_hold) hold_req = 1'b1;
                if (do_pause) wait_drained();
            end
            pick = $urandom_range(0, 99);
            if (pick < 8) load_sequence(10'($urandom()), $urandom_range(1, 4));
            else if (pick < 22) random_start();
            else if (pick < 27) random_load();
            else if (pick < 30) send_item(OP_UNUSED, random_fields());
            else do_tick();
        end
    endtask

    task automatic directed_part();
        // sequence wrapping past the top of the step memory
        load_step(10'd0, 8'd0, 16'h0000, 4'd0, 1'b0);
        load_step(10'd1023, 8'd2, 16'h0000, 4'd15, 1'b1);
        load_step(10'd1022, 8'd1, 16'hFFFF, 4'd15, 1'b0);
        // loop whose first step is an end step
        load_step(10'd5, 8'd0, 16'hFFFF, 4'd15, 1'b1);
        load_step(10'd22, 8'd0, 16'h0000, 4'd0, 1'b0);
        load_step(10'd21, 8'd1, 16'h1234, 4'd0, 1'b1);
        load_step(10'd20, 8'd1, 16'h8001, 4'd9, 1'b0);
        seq_heads.push_back(1022);
        seq_heads.push_back(5);
        seq_heads.push_back(20);
        start_channel(2'd0, 10'd1022, 1'b1, 1'b0);
        start_channel(2'd1, 10'd5, 1'b1, 1'b1);
        start_channel(2'd2, 10'd20, 1'b1, 1'b1);
        repeat (5) do_tick();
        start_channel(2'd3, 10'd1023, 1'b1, 1'b1);
        send_item(OP_UNUSED, random_fields());
        start_channel(2'd2, 10'd1023, 1'b0, 1'b0);
        start_channel(2'd1, 10'd0, 1'b0, 1'b1);
        load_step(10'd11, 8'd0, 16'h0000, 4'd0, 1'b0);
        load_step(10'd10, 8'd255, 16'hABCD, 4'd7, 1'b0);
        seq_heads.push_back(10);
        start_channel(2'd0, 10'd10, 1'b1, 1'b0);
        repeat (2) do_tick();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_tdata       = '0;
        s_tuser       = tss_pkg::OP_TICK;
        s_tvalid      = 1'b0;
        m_tready      = 1'b0;
        cfg_we        = 1'b0;
        cfg_idx       = tss_pkg::CFG_MUSIC_SCALE;
        cfg_data      = '0;
        error_count   = 0;
        cycle_count   = 0;
        sent_count    = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left     = 0;
        hold_req      = 1'b0;
        foreach (step_written[i]) step_written[i] = 1'b0;
        sb = new();
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        directed_part();

        wait_drained();
        write_scales(10'd0, 10'd1023);
        send_idle_pct = 26;
        recv_idle_pct = 45;
        run_random(60, 1'b1, 1'b0);

        wait_drained();
        write_scales(10'd1023, 10'd0);
        send_idle_pct = 45;
        recv_idle_pct = 26;
        run_random(60, 1'b0, 1'b1);

        wait_drained();
        write_scales(10'($urandom()), 10'($urandom()));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(60, 1'b0, 1'b0);

        wait_drained();
        if (sb.pending() != 0) report_mismatch("expected writes never arrived");
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+src
src/tss_pkg.sv
src/tss_step_mem.sv
src/tss_out_stage.sv
src/tone_step_sequencer_core.sv
sim/tb_tone_step_sequencer_core.sv
